[design/gtps_pkg.sv]
// Shared types and constants for the Gouraud triangle pixel shader.
// No dependencies; gtps_csr and the top level import this package.
`default_nettype none
package gtps_pkg;

   localparam int POS_W      = 10;
   localparam int CH_W       = 8;
   localparam int NUM_CH     = 3;
   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 32;
   localparam int EDGE_STEPS = POS_W;
   localparam int ROW_STEPS  = CH_W;
   localparam int EDGE_LAT   = EDGE_STEPS + 3;
   localparam int ROW_LAT    = ROW_STEPS + 3;
   localparam int LAST_STAGE = EDGE_LAT + 1 + ROW_LAT;
   localparam logic [CH_W-1:0] FULL_ALPHA = 8'hff;

   typedef enum logic [2:0] {
      REG_POS0,
      REG_POS1,
      REG_POS2,
      REG_RGB0,
      REG_RGB1,
      REG_RGB2
   } reg_index_type;

   typedef logic [CH_W-1:0] chan_type;

   // c[0] red, c[1] green, c[2] blue
   typedef struct packed {
      logic [POS_W-1:0]        x;
      logic [POS_W-1:0]        y;
      chan_type [NUM_CH-1:0]   c;
   } vertex_type;

   typedef vertex_type [2:0] tri_type;

endpackage
`default_nettype wire

[design/gtps_interp.sv]
// Pipelined integer interpolation a + (b - a) * (i - v1) / (v2 - v1).
// Restoring divider, one quotient bit per stage. Does not import gtps_pkg.
`default_nettype none
module gtps_interp #(
   parameter int VAL_W = 10,
   parameter int POS_W = 10,
   parameter int STEPS = 10
) (
   input  logic             clock,
   input  logic             en,
   input  logic [VAL_W-1:0] a,
   input  logic [VAL_W-1:0] b,
   input  logic [POS_W-1:0] v1,
   input  logic [POS_W-1:0] v2,
   input  logic [POS_W-1:0] i,
   output logic [VAL_W-1:0] res
);
   localparam int DIFF_W = VAL_W + 1;
   localparam int OFS_W  = POS_W + 1;
   localparam int PROD_W = DIFF_W + OFS_W;
   localparam int MAG_W  = VAL_W + POS_W;
   localparam int CMP_W  = MAG_W + STEPS;
   localparam int TRY_W  = CMP_W + 1;
   localparam int SUM_W  = VAL_W + STEPS + 2;

   // stage 1: differences
   logic [VAL_W-1:0]         a1_ff;
   logic signed [DIFF_W-1:0] diff1_ff;
   logic signed [OFS_W-1:0]  ofs1_ff;
   logic [POS_W-1:0]         den1_ff;
   logic                     zero1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff    <= a;
         diff1_ff <= signed'(DIFF_W'(b) - DIFF_W'(a));
         ofs1_ff  <= signed'(OFS_W'(i) - OFS_W'(v1));
         den1_ff  <= v2 - v1;
         zero1_ff <= (v2 == v1);
      end
   end

   // stage 2: product, split into sign and magnitude
   logic signed [PROD_W-1:0] prod;
   logic [PROD_W-1:0]        prod_abs;
   assign prod     = PROD_W'(diff1_ff) * PROD_W'(ofs1_ff);
   assign prod_abs = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

   logic [MAG_W-1:0] rem_ff  [STEPS+1];
   logic [STEPS-1:0] quo_ff  [STEPS+1];
   logic [POS_W-1:0] den_ff  [STEPS+1];
   logic [VAL_W-1:0] a_ff    [STEPS+1];
   logic             neg_ff  [STEPS+1];
   logic             zero_ff [STEPS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= prod_abs[MAG_W-1:0];
         quo_ff[0]  <= '0;
         den_ff[0]  <= den1_ff;
         a_ff[0]    <= a1_ff;
         neg_ff[0]  <= prod[PROD_W-1];
         zero_ff[0] <= zero1_ff;
      end
   end

   // divide stages, most significant quotient bit first
   for (genvar k = 1; k <= STEPS; k++) begin : g_div
      logic [TRY_W-1:0] trial;
      assign trial = TRY_W'(rem_ff[k-1]) - (TRY_W'(den_ff[k-1]) << (STEPS - k));

      always_ff @(posedge clock) begin
         if (en) begin
            if (!trial[TRY_W-1]) begin
               rem_ff[k] <= trial[MAG_W-1:0];
               quo_ff[k] <= quo_ff[k-1] | (STEPS'(1) << (STEPS - k));
            end else begin
               rem_ff[k] <= rem_ff[k-1];
               quo_ff[k] <= quo_ff[k-1];
            end
            den_ff[k]  <= den_ff[k-1];
            a_ff[k]    <= a_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
         end
      end
   end

   // final stage: apply sign, add start value, flat span keeps the start value
   logic [SUM_W-1:0] q_ext;
   logic [SUM_W-1:0] sum;
   logic [VAL_W-1:0] res_in, res_ff;
   assign q_ext = SUM_W'(quo_ff[STEPS]);
   assign sum   = SUM_W'(a_ff[STEPS]) + (neg_ff[STEPS] ? (SUM_W'(0) - q_ext) : q_ext);
   assign res_in = zero_ff[STEPS] ? a_ff[STEPS] : sum[VAL_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule
`default_nettype wire

[design/gtps_csr.sv]
// Configuration registers (APB-style) and y-ordering of the three vertices.
// Depends on gtps_pkg.
`default_nettype none
module gtps_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [gtps_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [gtps_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [gtps_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready,
   output gtps_pkg::tri_type             sorted
);
   import gtps_pkg::*;

   localparam int PW = 2 * POS_W;
   localparam int CW = NUM_CH * CH_W;

   logic [PW-1:0] pos_ff [3];
   logic [CW-1:0] rgb_ff [3];
   logic          wr_en;
   reg_index_type idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx        = reg_index_type'(csr_paddr[ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < 3; n++) begin
            pos_ff[n] <= '0;
            rgb_ff[n] <= '0;
         end
      end else if (wr_en) begin
         case (idx)
            REG_POS0: pos_ff[0] <= csr_pwdata[PW-1:0];
            REG_POS1: pos_ff[1] <= csr_pwdata[PW-1:0];
            REG_POS2: pos_ff[2] <= csr_pwdata[PW-1:0];
            REG_RGB0: rgb_ff[0] <= csr_pwdata[CW-1:0];
            REG_RGB1: rgb_ff[1] <= csr_pwdata[CW-1:0];
            REG_RGB2: rgb_ff[2] <= csr_pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_POS0: csr_prdata = DATA_W'(pos_ff[0]);
         REG_POS1: csr_prdata = DATA_W'(pos_ff[1]);
         REG_POS2: csr_prdata = DATA_W'(pos_ff[2]);
         REG_RGB0: csr_prdata = DATA_W'(rgb_ff[0]);
         REG_RGB1: csr_prdata = DATA_W'(rgb_ff[1]);
         REG_RGB2: csr_prdata = DATA_W'(rgb_ff[2]);
         default:  csr_prdata = '0;
      endcase
   end

   // unpack and order by y: (second,third), (first,third), (first,second)
   vertex_type v1, v2, v3, t;
   tri_type    sorted_in, sorted_ff;

   always_comb begin
      t = '0;
      v1.x = pos_ff[0][POS_W-1:0];
      v1.y = pos_ff[0][PW-1:POS_W];
      v2.x = pos_ff[1][POS_W-1:0];
      v2.y = pos_ff[1][PW-1:POS_W];
      v3.x = pos_ff[2][POS_W-1:0];
      v3.y = pos_ff[2][PW-1:POS_W];
      for (int k = 0; k < NUM_CH; k++) begin
         v1.c[k] = rgb_ff[0][CW-1-k*CH_W -: CH_W];
         v2.c[k] = rgb_ff[1][CW-1-k*CH_W -: CH_W];
         v3.c[k] = rgb_ff[2][CW-1-k*CH_W -: CH_W];
      end
      if (v2.y > v3.y) begin
         t = v2; v2 = v3; v3 = t;
      end
      if (v1.y > v3.y) begin
         t = v1; v1 = v3; v3 = t;
      end
      if (v1.y > v2.y) begin
         t = v1; v1 = v2; v2 = t;
      end
      sorted_in[0] = v1;
      sorted_in[1] = v2;
      sorted_in[2] = v3;
   end

   always_ff @(posedge clock) begin
      sorted_ff <= sorted_in;
   end

   assign sorted = sorted_ff;

   assert property (@(posedge clock) disable iff (reset)
      sorted[0].y <= sorted[1].y && sorted[1].y <= sorted[2].y)
      else $error("vertex order broken");
   assert property (@(posedge clock) disable iff (reset)
      wr_en && idx == REG_POS0 |=> pos_ff[0] == $past(csr_pwdata[PW-1:0]))
      else $error("position write lost");
   assert property (@(posedge clock)
      !reset && $past(reset) |-> pos_ff[0] == '0 && rgb_ff[2] == '0)
      else $error("registers not cleared by reset");

endmodule
`default_nettype wire

[design/gouraud_triangle_pixel_shader.sv]
// Top level of the Gouraud triangle pixel shader: input stage, edge and row
// interpolation pipelines. Depends on gtps_pkg, gtps_csr and gtps_interp.
//
// Usage:
//   Program the three vertex positions and colors through the csr_ port
//   (byte address 4*i) while no pixel is in flight. Then stream pixels in on
//   req_ (tdata = pixel_x, pixel_y); each transfer yields exactly one result
//   transfer on rsp_ (tuser = inside flag, tdata = red, green, blue, alpha).
//   From the req_ transfer to rsp_tvalid the path is one input register, the
//   edge interpolation (difference, multiply, ten-stage restoring divider,
//   add), one swap/span stage and the row interpolation (eight divider
//   stages). One pixel per clock is sustained while no result is held back;
//   the divider pipelines set the depth, not the rate. Reset clears all
//   valid bits and the configuration registers; no transfer is pending
//   afterward. When the receiver holds rsp_tready low with a result waiting,
//   the whole pipeline freezes and req_tready drops; once it is taken the
//   pipeline advances in the same cycle, so no item is lost or repeated.
//   Configuration edits in between take effect once stored and re-sorted.
`default_nettype none
module gouraud_triangle_pixel_shader #(
   parameter int DIAMETER = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [gtps_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [gtps_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [gtps_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready,
   // pixel requests
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,  // pixel_x[9:0], pixel_y[19:10], zero pad
   // shaded results
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [31:0]                   rsp_tdata,  // red, green, blue, alpha (8 bits each)
   output logic                          rsp_tuser   // inside_res
);
   import gtps_pkg::*;

   localparam int CMP_W = POS_W + 1;

   tri_type sorted;

   gtps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .sorted      (sorted)
   );

   // Advance everything together unless a result waits for the receiver.
   logic vld_ff [LAST_STAGE+1];
   logic adv;
   assign adv        = !vld_ff[LAST_STAGE] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n <= LAST_STAGE; n++) vld_ff[n] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int n = 1; n <= LAST_STAGE; n++) vld_ff[n] <= vld_ff[n-1];
      end
   end

   // input stage
   logic [POS_W-1:0] px_ff [EDGE_LAT+1];
   logic             ok_ff [EDGE_LAT+1];
   logic [POS_W-1:0] py_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff[0] <= req_tdata[POS_W-1:0];
         py_ff    <= req_tdata[2*POS_W-1:POS_W];
      end
   end

   // Row test: pixel on the image and between the top and bottom vertex.
   logic on_image, in_rows, upper;
   assign on_image = (CMP_W'(px_ff[0]) < CMP_W'(DIAMETER)) &&
                     (CMP_W'(py_ff) < CMP_W'(DIAMETER));
   assign in_rows  = (py_ff >= sorted[0].y) && (py_ff <= sorted[2].y);
   assign upper    = py_ff < sorted[1].y;

   always_comb begin
      ok_ff[0] = on_image && in_rows;
   end

   // carry pixel column and row verdict alongside the edge pipeline
   for (genvar k = 1; k <= EDGE_LAT; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (adv) begin
            px_ff[k] <= px_ff[k-1];
            ok_ff[k] <= ok_ff[k-1];
         end
      end
   end

   // left edge: upper short edge above the middle vertex, else lower short edge
   vertex_type ls, le;
   assign ls = upper ? sorted[0] : sorted[1];
   assign le = upper ? sorted[1] : sorted[2];

   logic [POS_W-1:0] xl_e, xr_e;
   chan_type         cl_e [NUM_CH];
   chan_type         cr_e [NUM_CH];

   gtps_interp #(.VAL_W(POS_W), .POS_W(POS_W), .STEPS(EDGE_STEPS)) u_xl (
      .clock (clock), .en (adv), .a (ls.x), .b (le.x),
      .v1 (ls.y), .v2 (le.y), .i (py_ff), .res (xl_e)
   );
   gtps_interp #(.VAL_W(POS_W), .POS_W(POS_W), .STEPS(EDGE_STEPS)) u_xr (
      .clock (clock), .en (adv), .a (sorted[0].x), .b (sorted[2].x),
      .v1 (sorted[0].y), .v2 (sorted[2].y), .i (py_ff), .res (xr_e)
   );

   for (genvar k = 0; k < NUM_CH; k++) begin : g_edge
      gtps_interp #(.VAL_W(CH_W), .POS_W(POS_W), .STEPS(EDGE_STEPS)) u_cl (
         .clock (clock), .en (adv), .a (ls.c[k]), .b (le.c[k]),
         .v1 (ls.y), .v2 (le.y), .i (py_ff), .res (cl_e[k])
      );
      gtps_interp #(.VAL_W(CH_W), .POS_W(POS_W), .STEPS(EDGE_STEPS)) u_cr (
         .clock (clock), .en (adv), .a (sorted[0].c[k]), .b (sorted[2].c[k]),
         .v1 (sorted[0].y), .v2 (sorted[2].y), .i (py_ff), .res (cr_e[k])
      );
   end

   // span stage: order the edges left to right and test the column
   logic             swap;
   logic [POS_W-1:0] px_e;
   logic [POS_W-1:0] xl_ff, xr_ff, pxc_ff;
   chan_type         cl_ff [NUM_CH];
   chan_type         cr_ff [NUM_CH];
   logic             ins_ff [ROW_LAT+1];
   logic             ins_in;

   assign swap   = xl_e > xr_e;
   assign px_e   = px_ff[EDGE_LAT];
   assign ins_in = ok_ff[EDGE_LAT] &&
                   (px_e >= (swap ? xr_e : xl_e)) && (px_e <= (swap ? xl_e : xr_e));

   always_ff @(posedge clock) begin
      if (adv) begin
         xl_ff     <= swap ? xr_e : xl_e;
         xr_ff     <= swap ? xl_e : xr_e;
         pxc_ff    <= px_e;
         ins_ff[0] <= ins_in;
         for (int k = 0; k < NUM_CH; k++) begin
            cl_ff[k] <= swap ? cr_e[k] : cl_e[k];
            cr_ff[k] <= swap ? cl_e[k] : cr_e[k];
         end
         for (int n = 1; n <= ROW_LAT; n++) ins_ff[n] <= ins_ff[n-1];
      end
   end

   // row interpolation, one unit per channel
   chan_type ch_o [NUM_CH];

   for (genvar k = 0; k < NUM_CH; k++) begin : g_row
      gtps_interp #(.VAL_W(CH_W), .POS_W(POS_W), .STEPS(ROW_STEPS)) u_row (
         .clock (clock), .en (adv), .a (cl_ff[k]), .b (cr_ff[k]),
         .v1 (xl_ff), .v2 (xr_ff), .i (pxc_ff), .res (ch_o[k])
      );
   end

   // drop color outside the span
   logic in_span;
   assign in_span    = ins_ff[ROW_LAT];
   assign rsp_tvalid = vld_ff[LAST_STAGE];
   assign rsp_tuser  = in_span;
   assign rsp_tdata  = in_span ? {FULL_ALPHA, ch_o[2], ch_o[1], ch_o[0]} : 32'd0;

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser ? rsp_tdata[31:24] == FULL_ALPHA : rsp_tdata == 32'd0))
      else $error("alpha and inside flag disagree");
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with no result pending");
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[EDGE_LAT+1] && ins_ff[0] |-> xl_ff <= pxc_ff && pxc_ff <= xr_ff)
      else $error("inside pixel outside its span");
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
`default_nettype wire
